### rtl/tcgr_pkg.sv
`timescale 1ns / 1ps

package tcgr_pkg;

    localparam int CODE_W    = 8;
    localparam int COORD_W   = 16;
    localparam int MASK_W    = 16;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_W     = 32;
    localparam int FONT_DEPTH = 4096;
    localparam int FONT_AW    = 12;
    localparam int GLYPH_ROWS = 16;
    localparam int GLYPH_COLS = 8;

    localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FG_COLOUR     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BG_COLOUR     = 4'd3;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [MASK_W-1:0]  mask_t;

    // glyph c row r: blank on the two top and bottom rows, c rotated left by (r-2) mod 8 else
    function automatic logic [7:0] font_byte(input logic [FONT_AW-1:0] addr);
        logic [7:0]  c;
        logic [3:0]  r;
        logic [2:0]  k;
        logic [15:0] dbl;
        c   = addr[FONT_AW-1:4];
        r   = addr[3:0];
        k   = 3'(r - 4'd2);
        dbl = {c, c} << k;
        if (r >= 4'd2 && r < 4'd14) begin
            return dbl[15:8];
        end
        return 8'd0;
    endfunction

endpackage

### rtl/tcgr_ram.sv
`timescale 1ns / 1ps

module tcgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/text_console_glyph_renderer_top.sv
`timescale 1ns / 1ps
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  char_code
// m_        out  m_tvalid/m_tready  pixel_x, pixel_y, fg_mask, in_bounds_mask; tlast = last
// cfg_      in   cfg_wr_en          screen_width, screen_height; fg/bg colour writes are ignored
//
// A drawn character gives 16*SCALE rows, one per unstalled cycle, set by the one ROM read port.
// Newlines and characters below the bottom are taken and give nothing.
// The next character is taken in the cycle its predecessor issues its final row read.
// After reset a sweep writes all 4096 font ROM entries; no request is taken until it ends.
// A stalled output holds the pipeline; the ROM read register holds with it.

module text_console_glyph_renderer_top #(
    parameter int SCALE    = 2,
    parameter int MARGIN_X = 64,
    parameter int MARGIN_Y = 64,
    parameter int LINE_GAP = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // char_code[7:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [63:0]                     m_tdata,   // pixel_x, pixel_y, fg_mask, in_bounds_mask
    output logic                            m_tlast,
    input  logic                            cfg_wr_en,
    input  logic [tcgr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcgr_pkg::CFG_W-1:0]      cfg_wdata
);

    localparam int GW    = tcgr_pkg::GLYPH_COLS * SCALE;
    localparam int GH    = tcgr_pkg::GLYPH_ROWS * SCALE;
    localparam int LINE  = GH + LINE_GAP;
    localparam int CNT_W = $clog2(GH);
    localparam int W     = tcgr_pkg::COORD_W;

    // configuration
    tcgr_pkg::coord_t width_reg, height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 16'd1920;
            height_reg <= 16'd1080;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                tcgr_pkg::REG_SCREEN_WIDTH:  width_reg  <= cfg_wdata[W-1:0];
                tcgr_pkg::REG_SCREEN_HEIGHT: height_reg <= cfg_wdata[W-1:0];
                default: ;
            endcase
        end
    end

    // font load sweep
    logic [tcgr_pkg::FONT_AW:0] fill_cnt_reg;
    logic                       fill_done;

    assign fill_done = fill_cnt_reg[tcgr_pkg::FONT_AW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_cnt_reg <= '0;
        end else if (!fill_done) begin
            fill_cnt_reg <= fill_cnt_reg + (tcgr_pkg::FONT_AW+1)'(1);
        end
    end

    // cursor and request decode
    tcgr_pkg::coord_t cur_col_reg, cur_row_reg;
    tcgr_pkg::coord_t col_w, row_w, row_line, col_adv;
    logic [W:0]       wrap_sum, line_sum, adv_sum, bot_sum;
    logic             is_nl, wrap, draw, s_accept;

    always_comb begin
        is_nl    = (s_tdata == tcgr_pkg::NEWLINE_CODE);
        line_sum = {1'b0, cur_row_reg} + (W+1)'(LINE);
        row_line = line_sum[W] ? {W{1'b1}} : line_sum[W-1:0];
        wrap_sum = {1'b0, cur_col_reg} + (W+1)'(GW + MARGIN_X);
        wrap     = is_nl || (wrap_sum > {1'b0, width_reg});
        col_w    = wrap ? W'(MARGIN_X) : cur_col_reg;
        row_w    = wrap ? row_line : cur_row_reg;
        bot_sum  = {1'b0, row_w} + (W+1)'(GH);
        draw     = !is_nl && !(bot_sum > {1'b0, height_reg});
        adv_sum  = {1'b0, col_w} + (W+1)'(GW);
        col_adv  = adv_sum[W] ? {W{1'b1}} : adv_sum[W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_col_reg <= W'(MARGIN_X);
            cur_row_reg <= W'(MARGIN_Y);
        end else if (s_accept) begin
            cur_col_reg <= draw ? col_adv : col_w;
            cur_row_reg <= row_w;
        end
    end

    // stage 1: row sequencer, issues ROM reads
    logic                       s1_active_reg;
    logic [CNT_W-1:0]           s1_cnt_reg;
    logic [tcgr_pkg::CODE_W-1:0] s1_code_reg;
    tcgr_pkg::coord_t           s1_col_reg, s1_row_reg;
    logic                       s1_last, issue;

    // stage 2: ROM data valid
    logic             v2_reg, s2_last_reg;
    tcgr_pkg::coord_t s2_col_reg, s2_py_reg;
    logic             s2_move, out_free;
    logic [7:0]       rom_data;

    assign s1_last  = (s1_cnt_reg == CNT_W'(GH - 1));
    assign out_free = !m_tvalid || m_tready;
    assign s2_move  = v2_reg && out_free;
    assign issue    = s1_active_reg && (!v2_reg || s2_move);
    assign s_tready = fill_done && (!s1_active_reg || (issue && s1_last));
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_active_reg <= 1'b0;
            s1_cnt_reg    <= '0;
        end else if (s_accept && draw) begin
            s1_active_reg <= 1'b1;
            s1_cnt_reg    <= '0;
        end else if (issue) begin
            s1_active_reg <= !s1_last;
            s1_cnt_reg    <= s1_cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && draw) begin
            s1_code_reg <= s_tdata;
            s1_col_reg  <= col_w;
            s1_row_reg  <= row_w;
        end
    end

    logic                          ram_re;
    logic [tcgr_pkg::FONT_AW-1:0]  ram_raddr;
    logic [3:0]                    glyph_row;

    assign ram_re    = issue;
    assign glyph_row = 4'(s1_cnt_reg / SCALE);
    assign ram_raddr = {s1_code_reg, glyph_row};

    tcgr_ram #(
        .WIDTH(8),
        .DEPTH(tcgr_pkg::FONT_DEPTH)
    ) u_font (
        .aclk (aclk),
        .we   (!fill_done),
        .waddr(fill_cnt_reg[tcgr_pkg::FONT_AW-1:0]),
        .wdata(tcgr_pkg::font_byte(fill_cnt_reg[tcgr_pkg::FONT_AW-1:0])),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(rom_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (issue) begin
            v2_reg <= 1'b1;
        end else if (s2_move) begin
            v2_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            s2_col_reg  <= s1_col_reg;
            s2_py_reg   <= s1_row_reg + W'(s1_cnt_reg);
            s2_last_reg <= s1_last;
        end
    end

    // masks
    logic [W:0]      rem;
    tcgr_pkg::mask_t inb, fg;
    logic            row_on;

    always_comb begin
        rem    = {1'b0, width_reg} - {1'b0, s2_col_reg};
        row_on = (s2_py_reg < height_reg) && !rem[W];
        inb    = '0;
        fg     = '0;
        for (int i = 0; i < tcgr_pkg::MASK_W; i++) begin
            if (i < GW && row_on && (rem > (W+1)'(i))) begin
                inb[i] = 1'b1;
                fg[i]  = rom_data[7 - (i / SCALE)];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (s2_move) begin
            m_tvalid <= 1'b1;
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_move) begin
            m_tdata <= {inb, fg, s2_py_reg, s2_col_reg};
            m_tlast <= s2_last_reg;
        end
    end

    a_no_draw_in_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        !fill_done |-> !s1_active_reg && !ram_re)
        else $error("row sequencer active during font load");

    a_accept_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s1_active_reg |-> issue && s1_last)
        else $error("request taken while a glyph is mid-sequence");

    a_s2_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && !out_free |=> v2_reg && $stable(s2_py_reg))
        else $error("stage 2 lost data under stall");

    a_out_from_s2: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(v2_reg))
        else $error("output valid without stage 2 data");

endmodule

### test/tb_text_console_glyph_renderer_top.sv
`timescale 1ns / 1ps

module tb_text_console_glyph_renderer_top;

    localparam int SCALE    = 2;
    localparam int MARGIN_X = 64;
    localparam int MARGIN_Y = 64;
    localparam int LINE_GAP = 8;

    localparam int GLYPH_W = tcgr_pkg::GLYPH_COLS * SCALE;
    localparam int GLYPH_H = tcgr_pkg::GLYPH_ROWS * SCALE;
    localparam int LINE_H  = GLYPH_H + LINE_GAP;

    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PRINT_LIMIT   = 40;

    localparam logic [tcgr_pkg::CFG_IDX_W-1:0] REG_SPARE_LOW  = 4'd4;
    localparam logic [tcgr_pkg::CFG_IDX_W-1:0] REG_SPARE_HIGH = 4'd15;

    typedef struct {
        tcgr_pkg::coord_t px;
        tcgr_pkg::coord_t py;
        tcgr_pkg::mask_t  fg;
        tcgr_pkg::mask_t  inb;
        logic             last;
    } span_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata   = 8'd0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [63:0]                    m_tdata;
    logic                           m_tlast;
    logic                           cfg_wr_en = 1'b0;
    logic [tcgr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [tcgr_pkg::CFG_W-1:0]     cfg_wdata = '0;

    // shadow copy of the configuration written to the block, and of its cursor
    int unsigned scr_w     = 1920;
    int unsigned scr_h     = 1080;
    logic [31:0] fg_colour = 32'd16777215;
    logic [31:0] bg_colour = 32'd13371;
    int unsigned cur_col   = MARGIN_X;
    int unsigned cur_row   = MARGIN_Y;

    logic [7:0] char_q[$];
    span_t      span_q[$];

    int errors      = 0;
    int spans_seen  = 0;
    int cycles      = 0;
    int burst_left  = 0;
    int gap_left    = 0;
    int hold_left   = 0;

    text_console_glyph_renderer_top #(
        .SCALE    (SCALE),
        .MARGIN_X (MARGIN_X),
        .MARGIN_Y (MARGIN_Y),
        .LINE_GAP (LINE_GAP)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int unsigned sat16(input int unsigned v);
        return (v > 32'hFFFF) ? 32'hFFFF : v;
    endfunction

    // blank top and bottom two rows; otherwise the code rotated left by (row-2) mod 8
    function automatic logic [7:0] glyph_bits(input logic [7:0] code, input int row);
        logic [7:0] b;
        int         k;
        b = 8'd0;
        if (row >= 2 && row < 14) begin
            b = code;
            k = (row - 2) % 8;
            repeat (k) b = {b[6:0], b[7]};
        end
        return b;
    endfunction

    task automatic render_char(input logic [7:0] code);
        logic [7:0]  bits;
        int unsigned py;
        span_t       s;
        if (code == tcgr_pkg::NEWLINE_CODE) begin
            cur_col = MARGIN_X;
            cur_row = sat16(cur_row + LINE_H);
            return;
        end
        if (cur_col + GLYPH_W + MARGIN_X > scr_w) begin
            cur_col = MARGIN_X;
            cur_row = sat16(cur_row + LINE_H);
        end
        if (cur_row + GLYPH_H > scr_h)
            return;
        for (int by = 0; by < tcgr_pkg::GLYPH_ROWS; by++) begin
            bits = glyph_bits(code, by);
            for (int sy = 0; sy < SCALE; sy++) begin
                py    = cur_row + by * SCALE + sy;
                s.px  = tcgr_pkg::coord_t'(cur_col);
                s.py  = tcgr_pkg::coord_t'(py);
                s.fg  = '0;
                s.inb = '0;
                for (int i = 0; i < GLYPH_W && i < tcgr_pkg::MASK_W; i++) begin
                    if (cur_col + i < scr_w && py < scr_h) begin
                        s.inb[i] = 1'b1;
                        if (bits[7 - i / SCALE])
                            s.fg[i] = 1'b1;
                    end
                end
                s.last = (by == tcgr_pkg::GLYPH_ROWS - 1) && (sy == SCALE - 1);
                span_q.push_back(s);
            end
        end
        cur_col = sat16(cur_col + GLYPH_W);
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] want,
                                   input logic [63:0] got);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("mismatch on %s at span %0d: expected %h, got %h",
                     field, spans_seen, want, got);
    endtask

    task automatic check_span();
        span_t want;
        if (span_q.size() == 0) begin
            report_mismatch("unexpected span", 64'd0, m_tdata);
            return;
        end
        want = span_q.pop_front();
        if (m_tdata[15:0] !== want.px)
            report_mismatch("pixel_x", 64'(want.px), 64'(m_tdata[15:0]));
        if (m_tdata[31:16] !== want.py)
            report_mismatch("pixel_y", 64'(want.py), 64'(m_tdata[31:16]));
        if (m_tdata[47:32] !== want.fg)
            report_mismatch("fg_mask", 64'(want.fg), 64'(m_tdata[47:32]));
        if (m_tdata[63:48] !== want.inb)
            report_mismatch("in_bounds_mask", 64'(want.inb), 64'(m_tdata[63:48]));
        if (m_tlast !== want.last)
            report_mismatch("tlast", 64'(want.last), 64'(m_tlast));
    endtask

    // request driver: bursts of random length, random gaps between them
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                render_char(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (char_q.size() > 0) begin
                    s_tdata  <= char_q.pop_front();
                    s_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // span monitor; stall pattern rotates through four modes, plus two long hold-offs
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                check_span();
                spans_seen++;
                if (spans_seen == 150 || spans_seen == 2500)
                    hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case ((cycles >> 9) % 4)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 0);
                    2: m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= ((cycles % 7) >= 2);
                endcase
            end
        end
    end

    task automatic write_reg(input logic [tcgr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            tcgr_pkg::REG_SCREEN_WIDTH:  scr_w     = value[15:0];
            tcgr_pkg::REG_SCREEN_HEIGHT: scr_h     = value[15:0];
            tcgr_pkg::REG_FG_COLOUR:     fg_colour = value;
            tcgr_pkg::REG_BG_COLOUR:     bg_colour = value;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        while (char_q.size() != 0 || s_tvalid || span_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_random(input int count, input int newline_one_in);
        for (int j = 0; j < count; j++) begin
            if ($urandom_range(0, newline_one_in - 1) == 0)
                char_q.push_back(tcgr_pkg::NEWLINE_CODE);
            else
                char_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset screen: glyph extremes, special codes, newline runs
        char_q = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h34, 8'h3B, 8'h41, 8'h55, 8'hAA,
                   tcgr_pkg::NEWLINE_CODE, 8'h7F, 8'hFE, tcgr_pkg::NEWLINE_CODE,
                   tcgr_pkg::NEWLINE_CODE, 8'h09, 8'h0B, 8'h20, 8'h0F, 8'hF0};
        queue_random(40, 8);
        wait_idle();

        // narrow screen: every glyph wraps to the margin
        write_reg(tcgr_pkg::REG_SCREEN_WIDTH, 32'd128);
        write_reg(tcgr_pkg::REG_SCREEN_HEIGHT, 32'hFFFF);
        queue_random(40, 6);
        wait_idle();

        // screen narrower than the glyph span: off-screen pixels cleared
        write_reg(tcgr_pkg::REG_SCREEN_WIDTH, 32'd70);
        char_q = '{8'hFF, 8'h81, 8'hC3};
        queue_random(7, 5);
        wait_idle();

        // widest screen, colour extremes
        write_reg(tcgr_pkg::REG_SCREEN_WIDTH, 32'hFFFF);
        write_reg(tcgr_pkg::REG_FG_COLOUR, 32'h0000_0000);
        write_reg(tcgr_pkg::REG_BG_COLOUR, 32'hFFFF_FFFF);
        queue_random(40, 8);
        wait_idle();

        // bottom close below the cursor: wraps and draws run into it
        write_reg(tcgr_pkg::REG_SCREEN_WIDTH, 32'd300);
        write_reg(tcgr_pkg::REG_SCREEN_HEIGHT, sat16(cur_row + 100));
        write_reg(tcgr_pkg::REG_FG_COLOUR, $urandom);
        write_reg(tcgr_pkg::REG_BG_COLOUR, $urandom);
        queue_random(40, 4);
        wait_idle();

        // smallest height, writes to unused indexes must change nothing
        write_reg(tcgr_pkg::REG_SCREEN_HEIGHT, 32'd32);
        write_reg(REG_SPARE_LOW, 32'd128);
        write_reg(REG_SPARE_HIGH, 32'd0);
        queue_random(10, 4);
        wait_idle();

        // fresh room, then a short fixed tail
        write_reg(tcgr_pkg::REG_SCREEN_HEIGHT, 32'hFFFF);
        write_reg(tcgr_pkg::REG_SCREEN_WIDTH, 32'd1000);
        queue_random(20, 8);
        char_q.push_back(8'h41);
        char_q.push_back(8'hFF);
        char_q.push_back(tcgr_pkg::NEWLINE_CODE);
        char_q.push_back(8'h00);
        wait_idle();

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
